[hdl/mhi_pkg.sv]
// shared types, constants and microcode rom for the max heap insert block
package mhi_pkg;

    // default heap capacity
    localparam int DEPTH_DEF = 128;

    // step counter width and step addresses of the microprogram
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_FETCH    = 4'd0;
    localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] ST_INS_CHK  = 4'd2;
    localparam logic [STEP_W-1:0] ST_RD_PAR   = 4'd3;
    localparam logic [STEP_W-1:0] ST_CMP      = 4'd4;
    localparam logic [STEP_W-1:0] ST_PLACE    = 4'd5;
    localparam logic [STEP_W-1:0] ST_FULL     = 4'd6;
    localparam logic [STEP_W-1:0] ST_READ     = 4'd7;
    localparam logic [STEP_W-1:0] ST_RD_CAP   = 4'd8;
    localparam logic [STEP_W-1:0] ST_BAD      = 4'd9;
    localparam logic [STEP_W-1:0] ST_EMIT     = 4'd10;

    // command codes carried on s_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    // jump condition select
    typedef enum logic [2:0] {
        C_ALWAYS      = 3'd0,
        C_IN_VALID    = 3'd1,
        C_CMD_READ    = 3'd2,
        C_FULL        = 3'd3,
        C_POS_ROOT    = 3'd4,
        C_PARENT_LESS = 3'd5,
        C_IDX_BAD     = 3'd6,
        C_OUT_FREE    = 3'd7
    } cond_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic cmd_read;
        logic full;
        logic pos_root;
        logic parent_less;
        logic idx_bad;
        logic out_free;
    } flags_t;

    // one control word
    typedef struct packed {
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              hold;
        logic              in_ready;
        logic              ld_pos;
        logic              rd_parent;
        logic              mv_if_less;
        logic              wr_value;
        logic              inc_count;
        logic              set_full;
        logic              rd_index;
        logic              cap_rdata;
        logic              set_bad;
        logic              emit;
    } ctrl_t;

    // microcode rom: taken jump when cond holds, else hold or fall through
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        unique case (step)
            ST_FETCH: begin
                w.in_ready = 1'b1;
                w.cond     = C_IN_VALID;
                w.target   = ST_DISPATCH;
                w.hold     = 1'b1;
            end
            ST_DISPATCH: begin
                w.cond   = C_CMD_READ;
                w.target = ST_READ;
            end
            ST_INS_CHK: begin
                w.ld_pos = 1'b1;
                w.cond   = C_FULL;
                w.target = ST_FULL;
            end
            ST_RD_PAR: begin
                w.rd_parent = 1'b1;
                w.cond      = C_POS_ROOT;
                w.target    = ST_PLACE;
            end
            ST_CMP: begin
                w.mv_if_less = 1'b1;
                w.cond       = C_PARENT_LESS;
                w.target     = ST_RD_PAR;
            end
            ST_PLACE: begin
                w.wr_value  = 1'b1;
                w.inc_count = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = ST_EMIT;
            end
            ST_FULL: begin
                w.set_full = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = ST_EMIT;
            end
            ST_READ: begin
                w.rd_index = 1'b1;
                w.cond     = C_IDX_BAD;
                w.target   = ST_BAD;
            end
            ST_RD_CAP: begin
                w.cap_rdata = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = ST_EMIT;
            end
            ST_BAD: begin
                w.set_bad = 1'b1;
                w.cond    = C_ALWAYS;
                w.target  = ST_EMIT;
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_OUT_FREE;
                w.target = ST_FETCH;
                w.hold   = 1'b1;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = ST_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

[hdl/mhi_seq.sv]
// microcode sequencer: step counter, control rom and conditional jumps
module mhi_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  mhi_pkg::flags_t flags,
    output mhi_pkg::ctrl_t  ctrl
);

    logic [mhi_pkg::STEP_W-1:0] step_reg;
    logic [mhi_pkg::STEP_W-1:0] step_next;
    logic                       cond_true;

    // control word of the current step
    assign ctrl = mhi_pkg::ucode(step_reg);

    // condition select
    always_comb begin
        unique case (ctrl.cond)
            mhi_pkg::C_ALWAYS:      cond_true = 1'b1;
            mhi_pkg::C_IN_VALID:    cond_true = flags.in_valid;
            mhi_pkg::C_CMD_READ:    cond_true = flags.cmd_read;
            mhi_pkg::C_FULL:        cond_true = flags.full;
            mhi_pkg::C_POS_ROOT:    cond_true = flags.pos_root;
            mhi_pkg::C_PARENT_LESS: cond_true = flags.parent_less;
            mhi_pkg::C_IDX_BAD:     cond_true = flags.idx_bad;
            mhi_pkg::C_OUT_FREE:    cond_true = flags.out_free;
            default:                cond_true = 1'b1;
        endcase
    end

    // next step: jump, hold or fall through
    always_comb begin
        if (cond_true) begin
            step_next = ctrl.target;
        end else if (ctrl.hold) begin
            step_next = step_reg;
        end else begin
            step_next = mhi_pkg::STEP_W'(step_reg + 1'b1);
        end
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= mhi_pkg::ST_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

[hdl/max_heap_insert.sv]
// binary max heap with sift-up insert and indexed read, microcoded datapath
// an insert sifts up with k parent moves, k <= log2(DEPTH); reads and dropped inserts do not
// one item at a time, next beat taken right after the result is loaded; the load
//   waits while an earlier result is held and m_tready is low
// reset: count and control clear on the clock edge, s_tready low; heap entries undefined until written
module max_heap_insert #(
    parameter int DEPTH = mhi_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // value[31:0], index[38:32], zero fill
    input  logic [0:0]  s_tuser,  // command[0]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // read_value[31:0], entry_count[39:32], status[41:40]
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

    mhi_pkg::ctrl_t  ctrl;
    mhi_pkg::flags_t flags;

    logic                    cmd_reg;
    logic signed [31:0]      val_reg;
    logic [6:0]              idx_reg;
    logic [ADDR_W-1:0]       pos_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [31:0]             rd_data_reg;
    logic [31:0]             res_value_reg;
    logic [1:0]              res_status_reg;
    logic                    m_valid_reg;
    logic [47:0]             m_data_reg;

    logic [31:0]             mem [DEPTH];
    logic [ADDR_W-1:0]       parent;
    logic                    in_accept;
    logic                    out_free;
    logic                    parent_less;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [31:0]             wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;

    // sequencer
    mhi_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // handshake and condition flags
    assign s_tready    = ctrl.in_ready && aresetn;
    assign in_accept   = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign parent      = ADDR_W'((pos_reg - 1'b1) >> 1);
    assign parent_less = $signed(rd_data_reg) < val_reg;

    always_comb begin
        flags.in_valid    = s_tvalid;
        flags.cmd_read    = (cmd_reg == mhi_pkg::CMD_READ);
        flags.full        = (count_reg == CNT_W'(DEPTH));
        flags.pos_root    = (pos_reg == '0);
        flags.parent_less = parent_less;
        flags.idx_bad     = !(CMP_W'(idx_reg) < CMP_W'(count_reg));
        flags.out_free    = out_free;
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg <= s_tuser[0];
            val_reg <= $signed(s_tdata[31:0]);
            idx_reg <= s_tdata[38:32];
        end
    end

    // heap ram ports: parent moves down or new value lands at pos
    assign wr_en   = (ctrl.mv_if_less && parent_less) || ctrl.wr_value;
    assign wr_addr = pos_reg;
    assign wr_data = ctrl.wr_value ? val_reg : rd_data_reg;
    assign rd_en   = (ctrl.rd_parent && !flags.pos_root) || (ctrl.rd_index && !flags.idx_bad);
    assign rd_addr = ctrl.rd_index ? ADDR_W'(idx_reg) : parent;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // sift position
    always_ff @(posedge aclk) begin
        if (ctrl.ld_pos) begin
            pos_reg <= ADDR_W'(count_reg);
        end else if (ctrl.mv_if_less && parent_less) begin
            pos_reg <= parent;
        end
    end

    // entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.inc_count) begin
            count_reg <= CNT_W'(count_reg + 1'b1);
        end
    end

    // result fields
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            res_value_reg  <= '0;
            res_status_reg <= mhi_pkg::STAT_OK;
        end else begin
            if (ctrl.cap_rdata) begin
                res_value_reg <= rd_data_reg;
            end
            if (ctrl.set_full) begin
                res_status_reg <= mhi_pkg::STAT_FULL;
            end else if (ctrl.set_bad) begin
                res_status_reg <= mhi_pkg::STAT_BAD;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.emit && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit && out_free) begin
            m_data_reg <= {6'd0, res_status_reg, 8'(count_reg), res_value_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // count stays within capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("heap count above capacity");

    // ram writes stay inside the filled region plus the new slot
    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (CNT_W'(pos_reg) <= count_reg))
        else $error("heap write beyond count");

    // count only ever grows by one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg)))
            |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("heap count changed by other than one");

    // an accepted item never lands while a sift is in progress
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> !wr_en && !rd_en)
        else $error("item accepted during heap access");

endmodule
